// ----- design/ats_pkg.sv -----
// Shared widths, constants and register codes for the arctan series evaluator.
package ats_pkg;

  localparam int FRAC_BITS = 14;
  localparam int X_W       = 16;
  localparam int POW_W     = 18;
  localparam int MAG_W     = POW_W - 1;
  localparam int RES_W     = 18;
  localparam int ACC_W     = 24;
  localparam int ET_W      = 5;

  localparam int MAX_TERMS_DEF = 32;

  localparam logic [ET_W-1:0] EXTRA_TERMS_RST = ET_W'(6);

  localparam logic signed [X_W-1:0] X_ONE     = X_W'(1 << FRAC_BITS);
  localparam logic signed [X_W-1:0] X_NEG_ONE = -X_ONE;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  localparam int ADDR_W = 3;

  typedef enum logic {
    REG_EXTRA_TERMS = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_idx_e;

endpackage

// ----- design/arctan_series_evaluator_core.sv -----
// Arctan series evaluator top level: sequencer, shared multiplier and APB register.
// Each request sums T = n+2 terms capped at MAX_TERMS, n being the extra-terms register.
// One request is in progress at a time: the next is taken only after the sequencer
// has moved its result into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous) empties the sequencer and output, n returns to 6.
module arctan_series_evaluator_core #(
  parameter int MAX_TERMS = ats_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ats_pkg::X_W-1:0]    x_value_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ats_pkg::RES_W-1:0]  arctan_value_o,
  output logic                              saturated_o,
  // APB register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ats_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // term index width; the divisor 2k+1 is the index with a one appended
  localparam int KW = $clog2(MAX_TERMS);
  localparam int DW = KW + 1;
  localparam int TW = (KW + 1 > 6) ? KW + 1 : 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_DSTART,
    ST_DWAIT,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e                                state_q;
  logic [ats_pkg::ET_W-1:0]              extra_terms_q;
  logic signed [ats_pkg::X_W-1:0]        x_q;
  logic [ats_pkg::X_W-1:0]               x2_q;
  logic signed [ats_pkg::POW_W-1:0]      power_q;
  logic signed [ats_pkg::ACC_W-1:0]      sum_q;
  logic [KW-1:0]                         k_q;
  logic [KW-1:0]                         last_k_q;
  logic                                  neg_q;
  logic                                  out_valid_q;
  logic signed [ats_pkg::RES_W-1:0]      res_q;
  logic                                  sat_q;

  // ---------------------------------------------------------------------------
  // Register port: one register at byte address zero, address bit 2 picks it
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (ats_pkg::reg_idx_e'(paddr[2]))
      ats_pkg::REG_EXTRA_TERMS: prdata = 32'(extra_terms_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_terms_q <= ats_pkg::EXTRA_TERMS_RST;
    end else if (cfg_wr && ats_pkg::reg_idx_e'(paddr[2]) == ats_pkg::REG_EXTRA_TERMS) begin
      extra_terms_q <= pwdata[ats_pkg::ET_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Request capture: clamp x to [-1, 1] and work out the index of the last term
  // ---------------------------------------------------------------------------
  logic                           in_acc;
  logic signed [ats_pkg::X_W-1:0] x_clamp;
  logic [TW-1:0]                  terms_full;
  logic [TW-1:0]                  terms_sel;
  logic [TW-1:0]                  last_full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    priority if (x_value_i > ats_pkg::X_ONE) begin
      x_clamp = ats_pkg::X_ONE;
    end else if (x_value_i < ats_pkg::X_NEG_ONE) begin
      x_clamp = ats_pkg::X_NEG_ONE;
    end else begin
      x_clamp = x_value_i;
    end
  end

  assign terms_full = TW'(extra_terms_q) + TW'(2);
  assign terms_sel  = (terms_full > TW'(MAX_TERMS)) ? TW'(MAX_TERMS) : terms_full;
  assign last_full  = terms_sel - TW'(1);

  // ---------------------------------------------------------------------------
  // Shared multiplier: x*x once per request, then power*x2 for each new term.
  // The product is taken down by FRAC_BITS with an arithmetic (flooring) shift.
  // ---------------------------------------------------------------------------
  logic signed [ats_pkg::POW_W-1:0]   mul_a;
  logic signed [ats_pkg::POW_W-1:0]   mul_b;
  logic signed [2*ats_pkg::POW_W-1:0] prod;
  logic signed [2*ats_pkg::POW_W-1:0] prod_sh;

  always_comb begin
    if (state_q == ST_SQR) begin
      mul_a = ats_pkg::POW_W'(x_q);
      mul_b = ats_pkg::POW_W'(x_q);
    end else begin
      mul_a = power_q;
      mul_b = $signed({{(ats_pkg::POW_W-ats_pkg::X_W){1'b0}}, x2_q});
    end
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> ats_pkg::FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Divider: magnitude of the power over 2k+1, sign restored on accumulation,
  // which gives the truncation toward zero
  // ---------------------------------------------------------------------------
  logic                            div_start;
  logic                            div_done;
  logic [ats_pkg::MAG_W-1:0]       div_quo;
  logic [ats_pkg::POW_W-1:0]       pow_abs;
  logic [DW-1:0]                   divisor;

  assign div_start = (state_q == ST_DSTART);
  assign pow_abs   = power_q[ats_pkg::POW_W-1] ? ats_pkg::POW_W'(-power_q)
                                                : ats_pkg::POW_W'(power_q);
  assign divisor   = {k_q, 1'b1};

  ats_div #(
    .DIV_W(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pow_abs[ats_pkg::MAG_W-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // subtract when exactly one of "odd term" and "negative power" holds
  logic                           term_sub;
  logic signed [ats_pkg::ACC_W-1:0] term_ext;
  logic signed [ats_pkg::ACC_W-1:0] sum_next;

  assign term_sub = k_q[0] ^ neg_q;
  assign term_ext = $signed(ats_pkg::ACC_W'(div_quo));
  assign sum_next = term_sub ? sum_q - term_ext : sum_q + term_ext;

  // ---------------------------------------------------------------------------
  // Saturation of the final sum to the result range
  // ---------------------------------------------------------------------------
  logic signed [ats_pkg::RES_W-1:0] res_clamp;
  logic                             res_sat;

  always_comb begin
    priority if (sum_q > ats_pkg::ACC_W'(ats_pkg::RES_MAX)) begin
      res_clamp = ats_pkg::RES_MAX;
      res_sat   = 1'b1;
    end else if (sum_q < ats_pkg::ACC_W'(ats_pkg::RES_MIN)) begin
      res_clamp = ats_pkg::RES_MIN;
      res_sat   = 1'b1;
    end else begin
      res_clamp = sum_q[ats_pkg::RES_W-1:0];
      res_sat   = 1'b0;
    end
  end

  // load the output register once it is free or being emptied this cycle
  logic res_load;
  assign res_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // Sequencer: square, then per term divide/accumulate and advance the power
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          k_q     <= '0;
          state_q <= ST_DSTART;
        end
        ST_DSTART: begin
          state_q <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            if (k_q == last_k_q) begin
              state_q <= ST_DONE;
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_q <= ST_DSTART;
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (res_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q      <= x_clamp;
      last_k_q <= last_full[KW-1:0];
    end
    if (state_q == ST_SQR) begin
      x2_q    <= prod_sh[ats_pkg::X_W-1:0];
      power_q <= ats_pkg::POW_W'(x_q);
      sum_q   <= '0;
    end
    if (state_q == ST_MUL) begin
      power_q <= prod_sh[ats_pkg::POW_W-1:0];
    end
    if (state_q == ST_DSTART) begin
      neg_q <= power_q[ats_pkg::POW_W-1];
    end
    if (state_q == ST_DWAIT && div_done) begin
      sum_q <= sum_next;
    end
    if (res_load) begin
      res_q <= res_clamp;
      sat_q <= res_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign arctan_value_o = res_q;
  assign saturated_o    = sat_q;

endmodule

// ----- design/ats_div.sv -----
// Restoring bit-serial divider: one quotient bit per cycle.
module ats_div #(
  parameter int DIV_W = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ats_pkg::MAG_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [ats_pkg::MAG_W-1:0]  quotient_o
);

  localparam int SW = $clog2(ats_pkg::MAG_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(ats_pkg::MAG_W - 1);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [SW-1:0]             cnt_q, cnt_d;
  logic [DIV_W-1:0]          rem_q, rem_d;
  logic [ats_pkg::MAG_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0]          dvs_q, dvs_d;
  logic [DIV_W:0]            trial;
  logic                      fits;

  // shift in the next dividend bit and try one subtract
  assign trial = {rem_q, quo_q[ats_pkg::MAG_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
      quo_d = {quo_q[ats_pkg::MAG_W-2:0], fits};
      cnt_d = cnt_q + SW'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/ats_checker.sv -----
// Port-level checker for the arctan series evaluator, bound to the top level.
module ats_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [ats_pkg::RES_W-1:0]  arctan_value_o,
  input logic                              saturated_o
);

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(arctan_value_o)
                                     && $stable(saturated_o))
    else $error("result changed or dropped while stalled");

  // one request at a time: busy right after acceptance
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a request is in progress");

  // no result can appear the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too soon after a request");

  // a clamped result sits on one of the range limits
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> arctan_value_o == ats_pkg::RES_MAX
                                   || arctan_value_o == ats_pkg::RES_MIN)
    else $error("saturation flag set on an unclamped result");

endmodule

bind arctan_series_evaluator_core ats_checker u_ats_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .arctan_value_o (arctan_value_o),
  .saturated_o    (saturated_o)
);
